/* hw/rtl/vca_pkg.sv */
// Shared types and constants of the Vorbis codeword assigner.
package vca_pkg;

  localparam int unsigned MaxCodeLenDef = 32;
  localparam int unsigned CodeLenW      = 6;
  localparam int unsigned WordW         = 32;

  // Lengths at or above this cannot overflow their marker word.
  localparam logic [CodeLenW-1:0] LongestLen = CodeLenW'(WordW);

  typedef struct packed {
    logic [WordW-1:0]    codeword;
    logic [CodeLenW-1:0] word_length;
    logic                has_code;
    logic                overfull;
  } vca_result_t;

endpackage

/* hw/rtl/vca_ram.sv */
// Generic single write port, single read port RAM with a registered read.
module vca_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/vca_out_reg.sv */
// Output register that holds one result beat until the sink takes it.
module vca_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  vca_pkg::vca_result_t res_i,
  output logic                 free_o,
  output logic                 valid_o,
  input  logic                 stall_i,
  output vca_pkg::vca_result_t res_o
);

  logic                 valid_q, valid_d;
  vca_pkg::vca_result_t res_q;

  // A new beat may load when the register is empty or being drained.
  assign free_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* hw/rtl/vorbis_codeword_assigner.sv */
// Top level: marker RAM walk that assigns Vorbis prefix codewords to entry lengths.
// An unused, out-of-range or overfull entry goes straight to the result; any other length L
// first walks the markers down from L, then walks them up above L.
// One item at a time: the next item is taken once the marker walk has finished
// and its result has been loaded into the output register, which waits while the sink stalls.
// Reset clears all marker valid bits at once (markers read as zero); no clearing pass.
module vorbis_codeword_assigner #(
  parameter int unsigned MAX_CODE_LEN = vca_pkg::MaxCodeLenDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [vca_pkg::CodeLenW-1:0] code_length_i,
  input  logic                         last_in_book_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [vca_pkg::WordW-1:0]    codeword_o,
  output logic [vca_pkg::CodeLenW-1:0] word_length_o,
  output logic                         has_code_o,
  output logic                         overfull_o
);

  localparam int unsigned AW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int unsigned JW = $clog2(MAX_CODE_LEN + 2);
  localparam int unsigned WW = vca_pkg::WordW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_DN   = 3'd2;
  localparam logic [2:0] S_DBL  = 3'd3;
  localparam logic [2:0] S_UPRD = 3'd4;
  localparam logic [2:0] S_UP   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]                   state_q, state_d;
  logic [JW-1:0]                j_q, j_d;
  logic [JW-1:0]                len_j_q, len_j_d;
  logic [vca_pkg::CodeLenW-1:0] len_q, len_d;
  logic                         last_q, last_d;
  logic [WW-1:0]                taken_q, taken_d;
  logic [WW-1:0]                prev_q, prev_d;
  vca_pkg::vca_result_t         res_q, res_d;

  logic [MAX_CODE_LEN-1:0]      valid_q;
  logic                         rd_vld_q;
  logic                         clear_valid;

  logic                         we, re;
  logic [JW-1:0]                wr_j, rd_j;
  logic [JW-1:0]                wr_jm1, rd_jm1;
  logic [AW-1:0]                waddr, raddr;
  logic [WW-1:0]                wdata, ram_rdata, mdata, mdata_inc, mdata_dbl, prev_dbl;

  logic                         out_load, out_free;
  vca_pkg::vca_result_t         out_res;

  // Marker j lives at RAM address j-1.
  assign wr_jm1 = wr_j - JW'(1);
  assign rd_jm1 = rd_j - JW'(1);
  assign waddr  = wr_jm1[AW-1:0];
  assign raddr  = rd_jm1[AW-1:0];

  vca_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_CODE_LEN)
  ) u_marker_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // A marker never written since the last clear reads as zero.
  assign mdata     = rd_vld_q ? ram_rdata : '0;
  assign mdata_inc = mdata + WW'(1);
  assign mdata_dbl = {mdata[WW-2:0], 1'b0};
  assign prev_dbl  = {prev_q[WW-2:0], 1'b0};

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    len_j_d     = len_j_q;
    len_d       = len_q;
    last_d      = last_q;
    taken_d     = taken_q;
    prev_d      = prev_q;
    res_d       = res_q;
    we          = 1'b0;
    wr_j        = j_q;
    wdata       = mdata_inc;
    re          = 1'b0;
    rd_j        = j_q;
    clear_valid = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          len_d   = code_length_i;
          len_j_d = code_length_i[JW-1:0];
          j_d     = code_length_i[JW-1:0];
          last_d  = last_in_book_i;
          res_d   = '0;
          if (code_length_i != '0 &&
              code_length_i <= vca_pkg::CodeLenW'(MAX_CODE_LEN)) begin
            re      = 1'b1;
            rd_j    = code_length_i[JW-1:0];
            state_d = S_CHK;
          end else begin
            state_d = S_FIN;
          end
        end
      end

      S_CHK, S_DN: begin
        if (state_q == S_CHK && len_q < vca_pkg::LongestLen &&
            (mdata >> len_q) != '0) begin
          res_d.overfull = 1'b1;
          state_d        = S_FIN;
        end else begin
          if (state_q == S_CHK) begin
            taken_d           = mdata;
            res_d.codeword    = mdata;
            res_d.word_length = len_q;
            res_d.has_code    = 1'b1;
          end
          // Advance this marker; an odd marker above one re-derives from the one below.
          if (mdata[0] && j_q != JW'(1)) begin
            re      = 1'b1;
            rd_j    = j_q - JW'(1);
            state_d = S_DBL;
          end else begin
            we    = 1'b1;
            wr_j  = j_q;
            wdata = mdata_inc;
            if (j_q == len_j_q) begin
              prev_d = mdata_inc;
            end
            if (mdata[0] || j_q == JW'(1)) begin
              state_d = S_UPRD;
            end else begin
              re      = 1'b1;
              rd_j    = j_q - JW'(1);
              j_d     = j_q - JW'(1);
              state_d = S_DN;
            end
          end
        end
      end

      S_DBL: begin
        we    = 1'b1;
        wr_j  = j_q;
        wdata = mdata_dbl;
        if (j_q == len_j_q) begin
          prev_d = mdata_dbl;
        end
        state_d = S_UPRD;
      end

      S_UPRD: begin
        if (len_j_q == JW'(MAX_CODE_LEN)) begin
          state_d = S_FIN;
        end else begin
          re      = 1'b1;
          rd_j    = len_j_q + JW'(1);
          j_d     = len_j_q + JW'(1);
          state_d = S_UP;
        end
      end

      S_UP: begin
        // Re-derive longer markers that hung off the taken code.
        if ({1'b0, mdata[WW-1:1]} == taken_q) begin
          we      = 1'b1;
          wr_j    = j_q;
          wdata   = prev_dbl;
          prev_d  = prev_dbl;
          taken_d = mdata;
          if (j_q == JW'(MAX_CODE_LEN)) begin
            state_d = S_FIN;
          end else begin
            re      = 1'b1;
            rd_j    = j_q + JW'(1);
            j_d     = j_q + JW'(1);
          end
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        clear_valid = last_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear_valid) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_q <= valid_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q     <= j_d;
    len_j_q <= len_j_d;
    len_q   <= len_d;
    last_q  <= last_d;
    taken_q <= taken_d;
    prev_q  <= prev_d;
    res_q   <= res_d;
  end

  vca_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .res_i   (res_q),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (out_res)
  );

  assign codeword_o    = out_res.codeword;
  assign word_length_o = out_res.word_length;
  assign has_code_o    = out_res.has_code;
  assign overfull_o    = out_res.overfull;

endmodule
